/* sv/compensated_dot_product_macros.svh */
// ----------------------------------------------------------------------------
// Compensated dot product assertion macros
// Concurrent assertion shorthands, removed when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef COMPENSATED_DOT_PRODUCT_MACROS_SVH
`define COMPENSATED_DOT_PRODUCT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on every clock edge outside reset.
`define CDP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define CDP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CDP_ASSERT(lbl, prop, msg)
`define CDP_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* sv/cdp_pkg.sv */
// ----------------------------------------------------------------------------
// Compensated dot product package
// Shared binary64 constants, pipeline tag type and register indexes.
// ----------------------------------------------------------------------------
package cdp_pkg;

  // Binary64 bit patterns.
  localparam logic [63:0] FP64_CANON_NAN = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] FP64_EXP_ALL   = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] FP64_ONE       = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] FP64_POS_ZERO  = 64'h0000_0000_0000_0000;
  localparam logic [10:0] FP64_EXP_MAX   = 11'h7FF;

  // Register word indexes on the configuration port.
  localparam logic REG_PRODUCT_MODE = 1'b0;

  // Control that travels alongside each pipeline stage.
  typedef struct packed {
    logic valid;
    logic last;
  } cdp_tag_t;

  // True when |p| < |q|; false when either value is a NaN.
  function automatic logic mag_less(input logic [63:0] p, input logic [63:0] q);
    logic any_nan;
    any_nan = (p[62:0] > FP64_EXP_ALL[62:0]) || (q[62:0] > FP64_EXP_ALL[62:0]);
    return !any_nan && (p[62:0] < q[62:0]);
  endfunction

endpackage

/* sv/cdp_fadd.sv */
// ----------------------------------------------------------------------------
// Binary64 adder
// Combinational IEEE-754 addition, round to nearest even, gradual underflow.
// ----------------------------------------------------------------------------
module cdp_fadd import cdp_pkg::*; (
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] sum_o
);

  logic        a_nan, b_nan, a_inf, b_inf;
  logic        swap;
  logic [63:0] big, sml;
  logic [11:0] e_big, e_sml, ediff;
  logic [55:0] m_big, m_sml, m_al;
  logic [111:0] shifted;
  logic        sticky;
  logic        eff_sub;
  logic [56:0] raw;
  logic [5:0]  lz;
  logic [11:0] shl;
  logic [55:0] norm;
  logic [11:0] e_norm;
  logic        rup;
  logic [53:0] rnd;
  logic [11:0] e_fin;
  logic [51:0] f_fin;

  // Leading zero count of the 56-bit working mantissa.
  function automatic logic [5:0] lzc56(input logic [55:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd56;
    found = 1'b0;
    for (int i = 55; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 6'(55 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  always_comb begin
    a_nan = (a_i[62:52] == FP64_EXP_MAX) && (a_i[51:0] != '0);
    b_nan = (b_i[62:52] == FP64_EXP_MAX) && (b_i[51:0] != '0);
    a_inf = (a_i[62:52] == FP64_EXP_MAX) && (a_i[51:0] == '0);
    b_inf = (b_i[62:52] == FP64_EXP_MAX) && (b_i[51:0] == '0);

    // Order the operands by magnitude.
    swap = b_i[62:0] > a_i[62:0];
    big  = swap ? b_i : a_i;
    sml  = swap ? a_i : b_i;
    e_big = {1'b0, (big[62:52] == '0) ? 11'd1 : big[62:52]};
    e_sml = {1'b0, (sml[62:52] == '0) ? 11'd1 : sml[62:52]};
    m_big = {big[62:52] != '0, big[51:0], 3'b000};
    m_sml = {sml[62:52] != '0, sml[51:0], 3'b000};
    ediff = e_big - e_sml;

    // Align the smaller operand, folding shifted-out bits into a sticky bit.
    shifted = '0;
    if (ediff >= 12'd57) begin
      m_al   = '0;
      sticky = |m_sml;
    end else begin
      shifted = {m_sml, 56'b0} >> ediff[5:0];
      m_al    = shifted[111:56];
      sticky  = |shifted[55:0];
    end
    m_al[0] = m_al[0] | sticky;

    eff_sub = big[63] ^ sml[63];
    raw = eff_sub ? ({1'b0, m_big} - {1'b0, m_al}) : ({1'b0, m_big} + {1'b0, m_al});

    // Normalize: one step right on carry out, else left up to the subnormal floor.
    lz = lzc56(raw[55:0]);
    if (raw[56]) begin
      shl    = '0;
      norm   = {raw[56:2], raw[1] | raw[0]};
      e_norm = e_big + 12'd1;
    end else begin
      shl    = ({6'b0, lz} < (e_big - 12'd1)) ? {6'b0, lz} : (e_big - 12'd1);
      norm   = raw[55:0] << shl;
      e_norm = e_big - shl;
    end

    // Round to nearest even on guard, round and sticky bits.
    rup = norm[2] & (norm[1] | norm[0] | norm[3]);
    rnd = {1'b0, norm[55:3]} + {53'b0, rup};
    if (rnd[53]) begin
      e_fin = e_norm + 12'd1;
      f_fin = '0;
    end else begin
      e_fin = rnd[52] ? e_norm : 12'd0;
      f_fin = rnd[51:0];
    end

    // Assemble, then let special operands override.
    if (raw == '0) begin
      sum_o = {eff_sub ? 1'b0 : big[63], 63'b0};
    end else if (e_fin >= {1'b0, FP64_EXP_MAX}) begin
      sum_o = {big[63], FP64_EXP_ALL[62:0]};
    end else begin
      sum_o = {big[63], e_fin[10:0], f_fin};
    end

    if (a_nan || b_nan || (a_inf && b_inf && (a_i[63] != b_i[63]))) begin
      sum_o = FP64_CANON_NAN;
    end else if (a_inf) begin
      sum_o = a_i;
    end else if (b_inf) begin
      sum_o = b_i;
    end
  end

endmodule

/* sv/cdp_fmul.sv */
// ----------------------------------------------------------------------------
// Binary64 multiplier
// Three-stage IEEE-754 multiply: partial products, product sum, round.
// ----------------------------------------------------------------------------
module cdp_fmul import cdp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  cdp_tag_t    tag_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output cdp_tag_t    tag_o,
  output logic [63:0] prod_o
);

  // Operand unpacking.
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [52:0] ma, mb;
  logic [11:0] e_sum_d;

  // Stage 1: partial products.
  cdp_tag_t    tag1_q;
  logic [53:0] pp_ll_q;
  logic [52:0] pp_lh_q, pp_hl_q;
  logic [51:0] pp_hh_q;
  logic [11:0] e_sum1_q;
  logic        sign1_q, nan1_q, inf1_q;

  // Stage 2: full product.
  cdp_tag_t     tag2_q;
  logic [105:0] prod2_q;
  logic [105:0] prod2_d;
  logic [11:0]  e_sum2_q;
  logic         sign2_q, nan2_q, inf2_q;

  // Stage 3: normalize and round.
  logic [6:0]         lz;
  logic signed [13:0] ee, sh;
  logic [6:0]         rs;
  logic [211:0]       wide;
  logic [105:0]       q;
  logic               st, rup;
  logic [53:0]        rnd;
  logic [12:0]        ebase, e_fin;
  logic [51:0]        f_fin;
  logic [63:0]        prod3_d;
  cdp_tag_t           tag3_q;
  logic [63:0]        prod3_q;

  function automatic logic [6:0] lzc106(input logic [105:0] v);
    logic [6:0] n;
    logic       found;
    n = 7'd106;
    found = 1'b0;
    for (int i = 105; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 7'(105 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  always_comb begin
    a_nan  = (a_i[62:52] == FP64_EXP_MAX) && (a_i[51:0] != '0);
    b_nan  = (b_i[62:52] == FP64_EXP_MAX) && (b_i[51:0] != '0);
    a_inf  = (a_i[62:52] == FP64_EXP_MAX) && (a_i[51:0] == '0);
    b_inf  = (b_i[62:52] == FP64_EXP_MAX) && (b_i[51:0] == '0);
    a_zero = (a_i[62:0] == '0);
    b_zero = (b_i[62:0] == '0);
    ma = {a_i[62:52] != '0, a_i[51:0]};
    mb = {b_i[62:52] != '0, b_i[51:0]};
    e_sum_d = {1'b0, (a_i[62:52] == '0) ? 11'd1 : a_i[62:52]}
            + {1'b0, (b_i[62:52] == '0) ? 11'd1 : b_i[62:52]};
  end

  // Stage 1 registers: four partial products of at most 27 by 27 bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
    end else if (en_i) begin
      tag1_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_ll_q  <= ma[26:0] * mb[26:0];
      pp_lh_q  <= ma[26:0] * mb[52:27];
      pp_hl_q  <= ma[52:27] * mb[26:0];
      pp_hh_q  <= ma[52:27] * mb[52:27];
      e_sum1_q <= e_sum_d;
      sign1_q  <= a_i[63] ^ b_i[63];
      nan1_q   <= a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
      inf1_q   <= a_inf || b_inf;
    end
  end

  // Stage 2: sum the partial products into the 106-bit product.
  assign prod2_d = {pp_hh_q, 54'b0} + {26'b0, pp_lh_q, 27'b0}
                 + {26'b0, pp_hl_q, 27'b0} + {52'b0, pp_ll_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag2_q <= '0;
    end else if (en_i) begin
      tag2_q <= tag1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod2_q  <= prod2_d;
      e_sum2_q <= e_sum1_q;
      sign2_q  <= sign1_q;
      nan2_q   <= nan1_q;
      inf2_q   <= inf1_q;
    end
  end

  // Stage 3: normalize, denormalize below the exponent floor, round.
  always_comb begin
    lz = lzc106(prod2_q);
    ee = $signed({2'b0, e_sum2_q}) - 14'sd1022 - $signed({7'b0, lz});
    sh = (ee >= 14'sd1) ? $signed({7'b0, lz}) : ($signed({7'b0, lz}) + ee - 14'sd1);
    ebase = (ee >= 14'sd1) ? ee[12:0] : 13'd1;
    rs   = '0;
    wide = '0;
    if (sh >= 14'sd0) begin
      q  = prod2_q << sh[6:0];
      st = 1'b0;
    end else if (-sh >= 14'sd107) begin
      q  = '0;
      st = |prod2_q;
    end else begin
      rs   = 7'(-sh);
      wide = {prod2_q, 106'b0} >> rs;
      q    = wide[211:106];
      st   = |wide[105:0];
    end

    rup = q[52] & ((|q[51:0]) | st | q[53]);
    rnd = {1'b0, q[105:53]} + {53'b0, rup};
    if (rnd[53]) begin
      e_fin = ebase + 13'd1;
      f_fin = '0;
    end else begin
      e_fin = rnd[52] ? ebase : 13'd0;
      f_fin = rnd[51:0];
    end

    if (nan2_q) begin
      prod3_d = FP64_CANON_NAN;
    end else if (inf2_q || (e_fin >= {2'b0, FP64_EXP_MAX})) begin
      prod3_d = {sign2_q, FP64_EXP_ALL[62:0]};
    end else if (prod2_q == '0) begin
      prod3_d = {sign2_q, 63'b0};
    end else begin
      prod3_d = {sign2_q, e_fin[10:0], f_fin};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag3_q <= '0;
    end else if (en_i) begin
      tag3_q <= tag2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod3_q <= prod3_d;
    end
  end

  assign tag_o  = tag3_q;
  assign prod_o = prod3_q;

endmodule

/* sv/compensated_dot_product.sv */
// ----------------------------------------------------------------------------
// Compensated dot product
// Registers: input, three multiplier stages, sum, compensation, correction
// and output. Throughput: one item per cycle unless a result is due while the
// output is held; the sum and correction loop adders are combinational.
// Reset: asynchronous, active low; clears both accumulators to +0.0 and sets
// product_mode to 1.
// ----------------------------------------------------------------------------
`include "compensated_dot_product_macros.svh"

module compensated_dot_product import cdp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] value_a_i,
  input  logic [63:0] value_b_i,
  input  logic        last_item_i,
  // Result stream.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] total_o
);

  logic        product_mode_q;
  logic        adv;

  // Input register.
  cdp_tag_t    s0_tag_q;
  logic [63:0] s0_a_q, s0_b_q;

  // Multiplier output.
  cdp_tag_t    s3_tag;
  logic [63:0] s3_z;

  // Sum loop.
  logic [63:0] s_q, t_d;
  cdp_tag_t    s4_tag_q;
  logic [63:0] s4_t_q, s4_s_q, s4_z_q;
  logic        s4_sel_q;

  // Compensation terms.
  logic [63:0] d1_d;
  cdp_tag_t    s5_tag_q;
  logic [63:0] s5_d1_q, s5_other_q, s5_t_q;
  logic [63:0] d_d;
  cdp_tag_t    s6_tag_q;
  logic [63:0] s6_d_q, s6_t_q;

  // Correction loop.
  logic [63:0] c_q, c_d;
  cdp_tag_t    s7_tag_q;
  logic [63:0] s7_c_q, s7_s_q;

  // Final sum and output register.
  logic [63:0] total_d;
  logic        out_valid_q;
  logic [63:0] out_total_q;
  logic        s7_result;

  // Configuration register; pready is always high, so no access is held off.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PRODUCT_MODE) ? {31'b0, product_mode_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      product_mode_q <= 1'b1;
    end else if (psel && penable && pwrite && (paddr[2] == REG_PRODUCT_MODE)) begin
      product_mode_q <= pwdata[0];
    end
  end

  // The whole pipeline moves unless a result is due while the output is held.
  assign s7_result  = s7_tag_q.valid && s7_tag_q.last;
  assign adv        = !(out_valid_q && !out_ready_i && s7_result);
  assign in_ready_o = adv;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_tag_q <= '0;
    end else if (adv) begin
      s0_tag_q <= '{valid: in_valid_i, last: last_item_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      s0_a_q <= value_a_i;
      s0_b_q <= value_b_i;
    end
  end

  // Term: a times b, or a times one in sum mode.
  cdp_fmul u_fmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .tag_i  (s0_tag_q),
    .a_i    (s0_a_q),
    .b_i    (product_mode_q ? s0_b_q : FP64_ONE),
    .tag_o  (s3_tag),
    .prod_o (s3_z)
  );

  // Running sum: t = sum + z.
  cdp_fadd u_add_sum (.a_i(s_q), .b_i(s3_z), .sum_o(t_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q      <= FP64_POS_ZERO;
      s4_tag_q <= '0;
    end else if (adv) begin
      s4_tag_q <= s3_tag;
      if (s3_tag.valid) begin
        s_q <= s3_tag.last ? FP64_POS_ZERO : t_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_t_q   <= t_d;
      s4_s_q   <= s_q;
      s4_z_q   <= s3_z;
      s4_sel_q <= mag_less(s_q, s3_z);
    end
  end

  // First compensation step: larger operand minus t.
  cdp_fadd u_add_d1 (
    .a_i   (s4_sel_q ? s4_z_q : s4_s_q),
    .b_i   ({~s4_t_q[63], s4_t_q[62:0]}),
    .sum_o (d1_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_tag_q <= '0;
    end else if (adv) begin
      s5_tag_q <= s4_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_d1_q    <= d1_d;
      s5_other_q <= s4_sel_q ? s4_s_q : s4_z_q;
      s5_t_q     <= s4_t_q;
    end
  end

  // Second compensation step: add back the smaller operand.
  cdp_fadd u_add_d2 (.a_i(s5_d1_q), .b_i(s5_other_q), .sum_o(d_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_tag_q <= '0;
    end else if (adv) begin
      s6_tag_q <= s5_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_d_q <= d_d;
      s6_t_q <= s5_t_q;
    end
  end

  // Correction accumulator.
  cdp_fadd u_add_corr (.a_i(c_q), .b_i(s6_d_q), .sum_o(c_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q      <= FP64_POS_ZERO;
      s7_tag_q <= '0;
    end else if (adv) begin
      s7_tag_q <= s6_tag_q;
      if (s6_tag_q.valid) begin
        c_q <= s6_tag_q.last ? FP64_POS_ZERO : c_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_c_q <= c_d;
      s7_s_q <= s6_t_q;
    end
  end

  // Total = sum + correction; the adder already gives the canonical NaN.
  cdp_fadd u_add_total (.a_i(s7_s_q), .b_i(s7_c_q), .sum_o(total_d));

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && s7_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s7_result) begin
      out_total_q <= total_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign total_o     = out_total_q;

  // Checks.
  `CDP_ASSERT(a_sum_restart, (adv && s3_tag.valid && s3_tag.last) |=> (s_q == FP64_POS_ZERO), "sum not cleared after last item")
  `CDP_ASSERT(a_corr_restart, (adv && s6_tag_q.valid && s6_tag_q.last) |=> (c_q == FP64_POS_ZERO), "correction not cleared after last item")
  `CDP_ASSERT(a_result_loaded, (adv && s7_result) |=> out_valid_q, "result transfer lost at output register")
  `CDP_ASSERT_RST(a_reset_empty, (!rst_ni) |-> (!out_valid_o && !s0_tag_q.valid), "pipeline not empty in reset")

endmodule

/* test/tb_compensated_dot_product.sv */
// ----------------------------------------------------------------------------
// Compensated dot product testbench
// Streams binary64 operand pairs through the block in both product and sum
// modes, predicts each total with native double arithmetic, and compares
// every result transfer with the oldest predicted total.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_compensated_dot_product;
  import cdp_pkg::*;

  // Operand pair waiting to be offered on the input stream.
  typedef struct {
    logic [63:0] a;
    logic [63:0] b;
    logic        last;
  } operand_pair_t;

  localparam int unsigned RESULT_LATENCY = 8;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned LONG_HOLD      = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [63:0] value_a_i;
  logic [63:0] value_b_i;
  logic        last_item_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [63:0] total_o;

  operand_pair_t pending_pairs[$];
  logic [63:0]   expected_totals[$];

  // Predicted accumulator state and the mode the block should hold.
  real         sum_acc;
  real         corr_acc;
  logic        mode_product;

  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned hold_left;
  int unsigned hold_req;
  int unsigned hold_ack;
  bit          send_burst;
  bit          recv_burst;
  logic [63:0] last_term;

  compensated_dot_product i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_a_i   (value_a_i),
    .value_b_i   (value_b_i),
    .last_item_i (last_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .total_o     (total_o)
  );

  // Clock generation.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Magnitude comparison that is false whenever either side is a NaN.
  function automatic bit magnitude_below(input logic [63:0] p, input logic [63:0] q);
    logic [62:0] mp;
    logic [62:0] mq;
    mp = p[62:0];
    mq = q[62:0];
    if (mp > 63'h7FF0_0000_0000_0000 || mq > 63'h7FF0_0000_0000_0000) return 1'b0;
    return mp < mq;
  endfunction

  // Fold one accepted pair into the predicted sum and correction.
  task automatic fold_pair(input operand_pair_t pair);
    real         term;
    real         t;
    real         d;
    logic [63:0] rb;
    term = mode_product ? $bitstoreal(pair.a) * $bitstoreal(pair.b) : $bitstoreal(pair.a);
    t = sum_acc + term;
    if (magnitude_below($realtobits(sum_acc), $realtobits(term))) begin
      d = term - t;
      d = d + sum_acc;
    end else begin
      d = sum_acc - t;
      d = d + term;
    end
    corr_acc = corr_acc + d;
    sum_acc  = t;
    if (pair.last) begin
      rb = $realtobits(sum_acc + corr_acc);
      if (rb[62:0] > FP64_EXP_ALL[62:0]) rb = FP64_CANON_NAN;
      expected_totals.push_back(rb);
      sum_acc  = 0.0;
      corr_acc = 0.0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
  endtask

  // Input driver: offers queued pairs with random gaps between transfers, or none in burst mode.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      value_a_i   <= '0;
      value_b_i   <= '0;
      last_item_i <= 1'b0;
      send_gap    <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        fold_pair('{a: value_a_i, b: value_b_i, last: last_item_i});
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap   <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          operand_pair_t nxt;
          nxt = pending_pairs.pop_front();
          value_a_i   <= nxt.a;
          value_b_i   <= nxt.b;
          last_item_i <= nxt.last;
          in_valid_i  <= 1'b1;
          send_gap    <= send_burst ? 0 : $urandom_range(0, 14);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, requested by the stimulus and counted here.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_ack  <= 0;
    end else if (hold_req != hold_ack) begin
      hold_left <= LONG_HOLD;
      hold_ack  <= hold_req;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor: checks each transfer and stalls at random or during a long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_gap    <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        int unsigned gap;
        if (expected_totals.size() == 0) begin
          report_mismatch("unexpected total", total_o, '0);
        end else begin
          logic [63:0] want;
          want = expected_totals.pop_front();
          if (total_o !== want) report_mismatch("total", total_o, want);
        end
        // A drawn wait of zero keeps the receiver ready for the next transfer.
        gap = recv_burst ? 0 : $urandom_range(0, 14);
        if (gap == 0) begin
          recv_gap    <= 0;
          out_ready_i <= 1'b1;
        end else begin
          recv_gap    <= gap - 1;
          out_ready_i <= 1'b0;
        end
      end else if (hold_left > 0 || hold_req != hold_ack) begin
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap    <= recv_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_compensated_dot_product NOT OK");
      $finish;
    end
  end

  // Register write over the configuration port; only called while idle.
  task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == {REG_PRODUCT_MODE, 2'b00}) mode_product = data[0];
  endtask

  // Wait until every queued pair is sent and every total has arrived.
  task automatic drain_stream;
    do @(negedge clk_i);
    while (pending_pairs.size() > 0 || in_valid_i || expected_totals.size() > 0);
    repeat (RESULT_LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic push_pair(input logic [63:0] a, input logic [63:0] b, input logic last);
    pending_pairs.push_back('{a: a, b: b, last: last});
  endtask

  // Operand drawn from a mix of ordinary and special binary64 classes.
  function automatic logic [63:0] pick_operand();
    int unsigned k;
    logic [63:0] r;
    logic        s;
    k = $urandom_range(0, 99);
    r = {$urandom, $urandom};
    s = r[63];
    if (k < 58)      return {s, 11'(1003 + $urandom_range(0, 40)), r[51:0]};
    else if (k < 70) return r;
    else if (k < 76) return {s, 63'h0};
    else if (k < 79) return {s, FP64_EXP_MAX, 52'h0};
    else if (k < 82) return {s, FP64_EXP_MAX, r[51:1], 1'b1};
    else if (k < 90) return {s, 11'h000, r[51:0]};
    else if (k < 95) return {s, 11'(2000 + $urandom_range(0, 46)), r[51:0]};
    else             return {s, 11'($urandom_range(1, 40)), r[51:0]};
  endfunction

  // Vectors of short random length; some items take the negated previous a operand times one.
  task automatic queue_vectors(input int unsigned n_items);
    int unsigned left;
    int unsigned len;
    logic [63:0] a;
    logic [63:0] b;
    left = n_items;
    while (left > 0) begin
      len = $urandom_range(1, 12);
      if (len > left) len = left;
      for (int unsigned i = 0; i < len; i++) begin
        a = pick_operand();
        b = pick_operand();
        if ($urandom_range(0, 4) == 0 && last_term != '0) begin
          a = {~last_term[63], last_term[62:0]};
          b = FP64_ONE;
        end
        last_term = a;
        push_pair(a, b, i == len - 1);
      end
      left -= len;
    end
  endtask

  // Stimulus sequence.
  initial begin
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    mode_product = 1'b1;
    hold_req     = 0;
    send_burst   = 1'b0;
    recv_burst   = 1'b0;
    last_term    = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Product mode from reset: single-item vectors, signed zeros, overflow,
    // infinity cancellation, NaN, underflow and catastrophic cancellation.
    push_pair(FP64_ONE, FP64_ONE, 1'b1);
    push_pair(FP64_POS_ZERO, {1'b1, 63'h0}, 1'b1);
    push_pair(64'h7FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF, 1'b1);
    push_pair({1'b0, FP64_EXP_MAX, 52'h0}, FP64_ONE, 1'b0);
    push_pair({1'b1, FP64_EXP_MAX, 52'h0}, FP64_ONE, 1'b1);
    push_pair(64'hFFF0_0000_0000_1234, FP64_ONE, 1'b1);
    push_pair(FP64_POS_ZERO, {1'b0, FP64_EXP_MAX, 52'h0}, 1'b1);
    push_pair(64'h0000_0000_0000_0001, 64'h3FE0_0000_0000_0000, 1'b1);
    push_pair($realtobits(1.0e16), FP64_ONE, 1'b0);
    push_pair(FP64_ONE, FP64_ONE, 1'b0);
    push_pair($realtobits(-1.0e16), FP64_ONE, 1'b1);
    push_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000, 1'b1);
    drain_stream();

    // Sum mode: value_b is ignored, including NaN patterns there.
    write_register({REG_PRODUCT_MODE, 2'b00}, 32'h0);
    push_pair($realtobits(1.0e100), 64'h7FF8_0000_0000_0001, 1'b0);
    push_pair(FP64_ONE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    push_pair($realtobits(-1.0e100), FP64_POS_ZERO, 1'b1);
    push_pair({1'b1, 63'h0}, FP64_ONE, 1'b1);
    push_pair(64'h0000_0000_0000_0001, FP64_ONE, 1'b0);
    push_pair(64'h0000_0000_0000_0001, FP64_ONE, 1'b1);
    push_pair(64'h7FEF_FFFF_FFFF_FFFF, FP64_ONE, 1'b0);
    push_pair(64'h7FEF_FFFF_FFFF_FFFF, FP64_ONE, 1'b1);
    drain_stream();

    // A write to an unused register index must leave the mode alone.
    write_register(3'd4, 32'hFFFF_FFFF);
    queue_vectors(300);
    drain_stream();

    // Product mode with the receiver held off while the sender keeps going.
    write_register({REG_PRODUCT_MODE, 2'b00}, 32'hFFFF_FFFF);
    send_burst = 1'b1;
    hold_req   = hold_req + 1;
    queue_vectors(400);
    drain_stream();
    send_burst = 1'b0;

    // Sum mode with a sender pause until all totals are in, then with a receiver that never waits.
    write_register({REG_PRODUCT_MODE, 2'b00}, 32'h0);
    queue_vectors(300);
    drain_stream();
    recv_burst = 1'b1;
    queue_vectors(300);
    drain_stream();
    recv_burst = 1'b0;

    // Product mode again, mixed burst and random pacing.
    write_register({REG_PRODUCT_MODE, 2'b00}, 32'h1);
    queue_vectors(400);
    drain_stream();
    send_burst = 1'b1;
    recv_burst = 1'b1;
    queue_vectors(300);
    drain_stream();

    if (error_count == 0) begin
      $display("tb_compensated_dot_product OK");
    end else begin
      $display("tb_compensated_dot_product NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/cdp_pkg.sv
sv/cdp_fadd.sv
sv/cdp_fmul.sv
sv/compensated_dot_product.sv
test/tb_compensated_dot_product.sv
